// File: sv/stok_pkg.sv
// Package for the source tokenizer: token kinds, scan modes and the
// command and status structs that join the controller and the datapath.
// It depends on nothing.
`default_nettype none
package stok_pkg;
    localparam logic [5:0] K_EOF   = 6'd0;
    localparam logic [5:0] K_IDENT = 6'd1;
    localparam logic [5:0] K_INT   = 6'd2;
    localparam logic [5:0] K_UNREC = 6'd44;

    localparam logic [23:0] POS_MAX = 24'hFFFFFF;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_HOLD    = 3'd1;
    localparam logic [2:0] MODE_IDENT   = 3'd2;
    localparam logic [2:0] MODE_NUM     = 3'd3;
    localparam logic [2:0] MODE_COMMENT = 3'd4;

    // Controller to datapath.
    typedef struct packed {
        logic       take;      // accept a byte and run the scan step
        logic       emit_next; // advance the emission pointer
    } stok_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       pending;   // a token (or end token) waits to be emitted
        logic       last;      // current emitted result is the final one
    } stok_sts_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_ident(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == 8'h5F;
    endfunction

    function automatic logic is_held(input logic [7:0] b);
        return b == "/" || b == "-" || b == ":" || b == "&" || b == "=" ||
               b == "!" || b == "<" || b == ">";
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        case (b)
            ".": return 6'd19;
            "(": return 6'd20;
            ")": return 6'd21;
            "{": return 6'd22;
            "}": return 6'd23;
            "[": return 6'd24;
            "]": return 6'd25;
            ",": return 6'd26;
            ";": return 6'd27;
            "+": return 6'd28;
            "*": return 6'd29;
            default: return K_UNREC;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] b);
        if (h == ":" && b == ":") return 6'd32;
        if (h == "&" && b == "&") return 6'd33;
        if (h == "-" && b == ">") return 6'd35;
        if (h == "=" && b == "=") return 6'd37;
        if (h == "=" && b == ">") return 6'd38;
        if (h == "!" && b == "=") return 6'd39;
        if (h == "<" && b == "=") return 6'd41;
        if (h == ">" && b == "=") return 6'd43;
        return 6'd0;
    endfunction

    function automatic logic [5:0] lone_kind(input logic [7:0] h);
        case (h)
            "/": return 6'd30;
            ":": return 6'd31;
            "-": return 6'd34;
            "=": return 6'd36;
            "<": return 6'd40;
            ">": return 6'd42;
            default: return K_UNREC;
        endcase
    endfunction

    // Keywords packed as up to nine bytes, first byte in the top bits.
    function automatic logic [5:0] word_kind(input logic [71:0] w, input logic [3:0] n);
        case ({n, w})
            {4'd2, 56'd0, "fn"}:        return 6'd3;
            {4'd6, 24'd0, "extern"}:    return 6'd4;
            {4'd6, 24'd0, "struct"}:    return 6'd5;
            {4'd4, 40'd0, "enum"}:      return 6'd6;
            {4'd3, 48'd0, "let"}:       return 6'd7;
            {4'd5, 32'd0, "alloc"}:     return 6'd8;
            {4'd4, 40'd0, "free"}:      return 6'd9;
            {4'd5, 32'd0, "match"}:     return 6'd10;
            {4'd2, 56'd0, "if"}:        return 6'd11;
            {4'd4, 40'd0, "else"}:      return 6'd12;
            {4'd5, 32'd0, "while"}:     return 6'd13;
            {4'd9, "invariant"}:        return 6'd14;
            {4'd8, 8'd0, "requires"}:   return 6'd15;
            {4'd8, 8'd0, "disjoint"}:   return 6'd16;
            {4'd7, 16'd0, "ensures"}:   return 6'd17;
            {4'd6, 24'd0, "return"}:    return 6'd18;
            default:                    return K_IDENT;
        endcase
    endfunction
endpackage
`default_nettype wire

// File: sv/stok_ctrl.sv
// Controller of the source tokenizer: accepts a byte when nothing is waiting
// to be emitted and paces the emission of results. Uses stok_pkg.
`default_nettype none
module stok_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire stok_pkg::stok_sts_t sts,
    output stok_pkg::stok_cmd_t    cmd
);
    import stok_pkg::*;

    localparam logic ST_SCAN = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.take = 1'b0;
        cmd.emit_next = 1'b0;
        unique case (state_reg)
            ST_SCAN:
            begin
                cmd.take = in_valid;
                if (in_valid)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Results drain here; the next byte waits until all have gone.
                if (!sts.pending)
                    state_next = ST_SCAN;
                else if (!out_stall)
                begin
                    cmd.emit_next = 1'b1;
                    if (sts.last)
                        state_next = ST_SCAN;
                end
            end
            default: state_next = ST_SCAN;
        endcase
    end

    assign in_stall  = (state_reg != ST_SCAN);
    assign out_valid = (state_reg == ST_EMIT) && sts.pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_SCAN;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// File: sv/stok_dp.sv
// Datapath of the source tokenizer: scan state, position counters, text
// store, value accumulator and the emission registers. Uses stok_pkg.
`default_nettype none
module stok_dp #(
    parameter int TEXT_LEN = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        char_in,
    input  wire stok_pkg::stok_cmd_t cmd,
    output stok_pkg::stok_sts_t    sts,
    output logic [5:0]             token_kind,
    output logic [23:0]            start_line,
    output logic [23:0]            start_col,
    output logic signed [63:0]     int_value,
    output logic [7:0]             text_char,
    output logic [4:0]             text_index,
    output logic                   last_of_token
);
    import stok_pkg::*;

    localparam int DEPTH = TEXT_LEN - 1;
    localparam int LW = $clog2(TEXT_LEN);
    localparam logic [LW-1:0] LMAX = LW'(DEPTH);
    localparam logic [63:0] LIM = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TENTH = 64'd922337203685477580; // LIM / 10

    logic [23:0] line_reg, line_next, col_reg, col_next;
    logic [23:0] tline_reg, tline_next, tcol_reg, tcol_next;
    logic [2:0]  mode_reg, mode_next;
    logic [7:0]  held_reg, held_next;
    // The first byte of a token lives in first_reg; the store holds the rest
    // from entry 1 upwards.
    logic [7:0]  store [DEPTH];
    logic [7:0]  first_reg, first_next;
    logic [LW-1:0] len_reg, len_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;

    // Emission: a token of len entries, then a single punctuator, then an end token.
    logic        tok_pend_reg, tok_pend_next;
    logic        eof_pend_reg, eof_pend_next;
    logic [LW-1:0] elen_reg, elen_next, eptr_reg;
    logic [5:0]  ekind_reg, ekind_next;
    logic [63:0] eval_reg, eval_next;
    logic [7:0]  efirst_reg, efirst_next;
    logic [23:0] eline_reg, eline_next, ecol_reg, ecol_next;
    logic [23:0] fline_reg, fline_next, fcol_reg, fcol_next;
    logic        s_pend_reg, s_pend_next;
    logic [7:0]  s_char_reg, s_char_next;
    logic [5:0]  s_kind_reg, s_kind_next;
    logic [23:0] s_line_reg, s_line_next, s_col_reg, s_col_next;

    logic        wr_en;
    logic [LW-1:0] wr_addr;
    logic [71:0] word;
    logic [3:0]  word_len;

    always_comb
    begin
        word = '0;
        for (int i = 0; i < 9; i++)
            if (i < DEPTH && LW'(i) < len_reg)
                word = {word[63:0], (i == 0) ? first_reg : store[i]};
    end

    // Words longer than nine bytes can never be keywords.
    assign word_len = (int'(len_reg) > 9) ? 4'd15 : 4'(len_reg);

    always_comb
    begin
        logic [7:0] b;
        logic       redo;
        logic [63:0] d;
        logic [5:0] pk;
        b = char_in;
        redo = 1'b0;
        d = {60'd0, b[3:0]};
        pk = pair_kind(held_reg, b);
        line_next = line_reg; col_next = col_reg;
        tline_next = tline_reg; tcol_next = tcol_reg;
        mode_next = mode_reg; held_next = held_reg;
        len_next = len_reg; acc_next = acc_reg; neg_next = neg_reg;
        first_next = first_reg; efirst_next = efirst_reg;
        tok_pend_next = tok_pend_reg; eof_pend_next = eof_pend_reg;
        elen_next = elen_reg; ekind_next = ekind_reg; eval_next = eval_reg;
        eline_next = eline_reg; ecol_next = ecol_reg;
        fline_next = fline_reg; fcol_next = fcol_reg;
        s_pend_next = s_pend_reg; s_char_next = s_char_reg; s_kind_next = s_kind_reg;
        s_line_next = s_line_reg; s_col_next = s_col_reg;
        wr_en = 1'b0; wr_addr = len_reg;

        if (cmd.emit_next)
        begin
            if (tok_pend_reg)
            begin
                if (eptr_reg + 1'b1 == elen_reg)
                    tok_pend_next = 1'b0;
            end
            else if (s_pend_reg)
                s_pend_next = 1'b0;
            else
                eof_pend_next = 1'b0;
        end

        if (cmd.take)
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_ident(b))
                    begin
                        if (len_reg < LMAX) begin wr_en = 1'b1; len_next = len_reg + 1'b1; end
                    end
                    else
                    begin
                        tok_pend_next = 1'b1; ekind_next = word_kind(word, word_len);
                        eval_next = '0; redo = 1'b1;
                    end
                end
                MODE_NUM:
                begin
                    if (is_digit(b))
                    begin
                        if (len_reg < LMAX)
                        begin
                            wr_en = 1'b1; len_next = len_reg + 1'b1;
                            // (LIM - d) / 10 equals TENTH minus one when d > 8.
                            if (acc_reg > (d > 64'd8 ? TENTH - 64'd1 : TENTH))
                                acc_next = LIM;
                            else
                                acc_next = (acc_reg << 3) + (acc_reg << 1) + d;
                        end
                    end
                    else
                    begin
                        tok_pend_next = 1'b1; ekind_next = K_INT; redo = 1'b1;
                        if (neg_reg)
                            eval_next = 64'd0 - acc_reg;
                        else
                            eval_next = acc_reg[63] ? 64'h7FFF_FFFF_FFFF_FFFF : acc_reg;
                    end
                end
                MODE_COMMENT:
                begin
                    if (b != 8'd0 && b != 8'h0A) ;
                    else begin mode_next = MODE_IDLE; redo = 1'b1; end
                end
                MODE_HOLD:
                begin
                    if (held_reg == "/" && b == "/")
                        mode_next = MODE_COMMENT;
                    else if (held_reg == "-" && is_digit(b))
                    begin
                        wr_en = 1'b1; len_next = len_reg + 1'b1;
                        neg_next = 1'b1; acc_next = d; mode_next = MODE_NUM;
                    end
                    else if (pk != 6'd0)
                    begin
                        wr_en = 1'b1; len_next = len_reg + 1'b1;
                        tok_pend_next = 1'b1; ekind_next = pk; eval_next = '0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        tok_pend_next = 1'b1; ekind_next = lone_kind(held_reg);
                        eval_next = '0; redo = 1'b1;
                    end
                end
                default: redo = 1'b1;
            endcase

            if (tok_pend_next)
            begin
                elen_next = len_next; eline_next = tline_reg; ecol_next = tcol_reg;
                efirst_next = first_reg;
            end

            if (redo)
            begin
                mode_next = MODE_IDLE;
                if (b == 8'd0)
                begin
                    eof_pend_next = 1'b1; fline_next = line_reg; fcol_next = col_reg;
                    line_next = 24'd1; col_next = 24'd1;
                    tline_next = 24'd1; tcol_next = 24'd1;
                    held_next = '0; len_next = '0; acc_next = '0; neg_next = 1'b0;
                end
                else if (!is_space(b))
                begin
                    tline_next = line_reg; tcol_next = col_reg;
                    first_next = b; len_next = LW'(1);
                    if (is_alpha(b) || b == 8'h5F)
                        mode_next = MODE_IDENT;
                    else if (is_digit(b))
                    begin
                        mode_next = MODE_NUM; neg_next = 1'b0; acc_next = d;
                    end
                    else if (is_held(b))
                    begin
                        held_next = b; mode_next = MODE_HOLD;
                    end
                    else
                    begin
                        // A single punctuator has its own result register, so a
                        // token that ended on the same byte still drains first.
                        s_pend_next = 1'b1; s_kind_next = single_kind(b);
                        s_char_next = b; s_line_next = line_reg; s_col_next = col_reg;
                    end
                end
            end

            if (b != 8'd0)
            begin
                if (b == 8'h0A)
                begin
                    if (line_reg < POS_MAX) line_next = line_reg + 24'd1;
                    col_next = 24'd1;
                end
                else if (col_reg < POS_MAX)
                    col_next = col_reg + 24'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_addr[LW-1:0] < LMAX ? wr_addr : '0] <= char_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= 24'd1; col_reg <= 24'd1; tline_reg <= 24'd1; tcol_reg <= 24'd1;
            mode_reg <= MODE_IDLE; held_reg <= '0; len_reg <= '0;
            acc_reg <= '0; neg_reg <= 1'b0;
            tok_pend_reg <= 1'b0; eof_pend_reg <= 1'b0; eptr_reg <= '0;
            s_pend_reg <= 1'b0;
        end
        else
        begin
            line_reg <= line_next; col_reg <= col_next;
            tline_reg <= tline_next; tcol_reg <= tcol_next;
            mode_reg <= mode_next; held_reg <= held_next; len_reg <= len_next;
            acc_reg <= acc_next; neg_reg <= neg_next;
            tok_pend_reg <= tok_pend_next; eof_pend_reg <= eof_pend_next;
            s_pend_reg <= s_pend_next;
            if (cmd.take)
                eptr_reg <= '0;
            else if (cmd.emit_next && tok_pend_reg)
                eptr_reg <= eptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        elen_reg <= elen_next; ekind_reg <= ekind_next; eval_reg <= eval_next;
        eline_reg <= eline_next; ecol_reg <= ecol_next;
        fline_reg <= fline_next; fcol_reg <= fcol_next;
        first_reg <= first_next; efirst_reg <= efirst_next;
        s_char_reg <= s_char_next; s_kind_reg <= s_kind_next;
        s_line_reg <= s_line_next; s_col_reg <= s_col_next;
    end

    logic [7:0] rd_char;
    assign rd_char = (eptr_reg == '0) ? efirst_reg : store[eptr_reg < LMAX ? eptr_reg : '0];

    always_comb
    begin
        sts.pending = tok_pend_reg || eof_pend_reg || s_pend_reg;
        if (tok_pend_reg)
        begin
            token_kind = ekind_reg; start_line = eline_reg; start_col = ecol_reg;
            int_value = eval_reg; text_char = rd_char;
            text_index = 5'(eptr_reg);
            last_of_token = (eptr_reg + 1'b1 == elen_reg);
            sts.last = last_of_token && !eof_pend_reg && !s_pend_reg;
        end
        else if (s_pend_reg)
        begin
            token_kind = s_kind_reg; start_line = s_line_reg; start_col = s_col_reg;
            int_value = '0; text_char = s_char_reg; text_index = '0;
            last_of_token = 1'b1; sts.last = 1'b1;
        end
        else
        begin
            token_kind = K_EOF; start_line = fline_reg; start_col = fcol_reg;
            int_value = '0; text_char = '0; text_index = '0;
            last_of_token = 1'b1; sts.last = 1'b1;
        end
    end
endmodule
`default_nettype wire

// File: sv/source_tokenizer.sv
// Source tokenizer: one source byte per input transaction on char_in, with
// 0 marking the end of source. Whitespace and line comments are skipped.
// Each token leaves as a run of output transactions, one per kept text byte,
// with last_of_token high on the final one; the end of source gives one end
// token and returns the block to line 1, column 1.
// Each byte is scanned as it is taken; its results then drain at one per cycle
// while out_stall is low, and the next byte is taken once they have all gone.
// The controller state machine sets this pace.
// After reset the block waits between tokens at line 1, column 1.
// When the receiver stalls, the current result holds and in_stall stays high.
// Depends on stok_pkg, stok_ctrl and stok_dp.
`default_nettype none
module source_tokenizer #(
    parameter int TEXT_LEN = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        char_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [5:0]             token_kind,
    output logic [23:0]            start_line,
    output logic [23:0]            start_col,
    output logic signed [63:0]     int_value,
    output logic [7:0]             text_char,
    output logic [4:0]             text_index,
    output logic                   last_of_token
);
    import stok_pkg::*;

    stok_cmd_t cmd;
    stok_sts_t sts;

    stok_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
    );

    stok_dp #(.TEXT_LEN(TEXT_LEN)) u_dp (
        .clk(clk), .rst_n(rst_n), .char_in(char_in), .cmd(cmd), .sts(sts),
        .token_kind(token_kind), .start_line(start_line), .start_col(start_col),
        .int_value(int_value), .text_char(text_char), .text_index(text_index),
        .last_of_token(last_of_token)
    );
endmodule
`default_nettype wire

// File: bench/tb_source_tokenizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for source_tokenizer: a directed table of source bytes,
// then random streams of tokens, blanks, comments and arbitrary bytes, all checked against an in-bench scanner.
// Depends on stok_pkg and source_tokenizer.
module tb_source_tokenizer;
    import stok_pkg::*;

    localparam int KEEP_MAX = 31;

    localparam logic [5:0] K_KW_FIRST = 6'd3;
    localparam logic [5:0] K_DOT = 6'd19, K_LPAREN = 6'd20, K_RPAREN = 6'd21;
    localparam logic [5:0] K_LBRACE = 6'd22, K_RBRACE = 6'd23, K_LBRACK = 6'd24;
    localparam logic [5:0] K_RBRACK = 6'd25, K_COMMA = 6'd26, K_SEMI = 6'd27;
    localparam logic [5:0] K_PLUS = 6'd28, K_STAR = 6'd29, K_SLASH = 6'd30;
    localparam logic [5:0] K_COLON = 6'd31, K_PATH = 6'd32, K_ANDAND = 6'd33;
    localparam logic [5:0] K_MINUS = 6'd34, K_ARROW = 6'd35, K_ASSIGN = 6'd36;
    localparam logic [5:0] K_EQEQ = 6'd37, K_FATARROW = 6'd38, K_NOTEQ = 6'd39;
    localparam logic [5:0] K_LT = 6'd40, K_LE = 6'd41, K_GT = 6'd42, K_GE = 6'd43;

    typedef enum logic [2:0] {SC_IDLE, SC_HOLD, SC_WORD, SC_NUM, SC_NOTE} scan_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] line;
        logic [23:0] col;
        logic [63:0] value;
        logic [7:0]  ch;
        logic [4:0]  idx;
        logic        last;
    } token_byte_t;

    typedef struct {
        logic [7:0]  ch;
        bit          typed;
        token_byte_t res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] char_in = 8'd0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [5:0] token_kind;
    logic [23:0] start_line, start_col;
    logic signed [63:0] int_value;
    logic [7:0] text_char;
    logic [4:0] text_index;
    logic last_of_token;

    source_tokenizer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .char_in(char_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .start_line(start_line), .start_col(start_col),
        .int_value(int_value), .text_char(text_char), .text_index(text_index),
        .last_of_token(last_of_token)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Scanner state mirrored in the bench.
    logic [23:0] cur_line, cur_col, tok_line, tok_col;
    scan_t       mode;
    logic [7:0]  held;
    logic [7:0]  kept [KEEP_MAX];
    int          kept_len;
    logic [63:0] accum;
    bit          negative;

    token_byte_t expected_bytes[$];
    token_byte_t fresh[$];
    logic [7:0]  source_bytes[$];
    int          errors = 0;
    int          sender_idle_pct = 0;
    int          stall_pct = 0;

    string keywords [16] = '{"fn", "extern", "struct", "enum", "let", "alloc", "free",
        "match", "if", "else", "while", "invariant", "requires", "disjoint",
        "ensures", "return"};
    string puncts [33] = '{".", "(", ")", "{", "}", "[", "]", ",", ";", "+", "*",
        "::", "&&", "->", "==", "=>", "!=", "<=", ">=", "&", "!", "/", ":", "-",
        "=", "<", ">", "<<", "=<", "-->", "!!", ">>=", "&&&"};
    string blanks = " \t\n\v\f\r";

    function automatic bit is_blank(logic [7:0] b);
        return b == " " || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_word(logic [7:0] b);
        return is_letter(b) || is_num(b) || b == "_";
    endfunction

    task automatic clear_scanner();
        cur_line = 24'd1; cur_col = 24'd1; tok_line = 24'd1; tok_col = 24'd1;
        mode = SC_IDLE; held = 8'd0; kept_len = 0; accum = 64'd0; negative = 1'b0;
    endtask

    task automatic step_position(logic [7:0] b);
        if (b == "\n")
        begin
            if (cur_line < POS_MAX) cur_line++;
            cur_col = 24'd1;
        end
        else if (cur_col < POS_MAX)
            cur_col++;
    endtask

    task automatic keep_byte(logic [7:0] b);
        if (kept_len < KEEP_MAX)
        begin
            kept[kept_len] = b;
            kept_len++;
        end
    endtask

    task automatic add_digit(logic [7:0] b);
        logic [63:0] d;
        logic [63:0] lim;
        d = 64'(b - "0");
        lim = 64'h8000_0000_0000_0000;
        if (accum > (lim - d) / 10) accum = lim;
        else accum = accum * 10 + d;
    endtask

    task automatic flush_token(logic [5:0] kind, logic [63:0] value);
        for (int i = 0; i < kept_len; i++)
            fresh.push_back('{kind, tok_line, tok_col, value, kept[i], 5'(i),
                              i + 1 == kept_len});
        kept_len = 0;
        mode = SC_IDLE;
    endtask

    function automatic logic [5:0] word_code();
        bit same;
        for (int k = 0; k < 16; k++)
        begin
            same = keywords[k].len() == kept_len;
            for (int i = 0; same && i < kept_len; i++)
                same = keywords[k][i] == kept[i];
            if (same) return K_KW_FIRST + 6'(k);
        end
        return K_IDENT;
    endfunction

    function automatic logic [63:0] number_value();
        if (negative) return 64'd0 - accum;
        return accum > 64'h7FFF_FFFF_FFFF_FFFF ? 64'h7FFF_FFFF_FFFF_FFFF : accum;
    endfunction

    function automatic logic [5:0] single_code(logic [7:0] b);
        case (b)
            ".": return K_DOT;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            ",": return K_COMMA;
            ";": return K_SEMI;
            "+": return K_PLUS;
            "*": return K_STAR;
            default: return K_UNREC;
        endcase
    endfunction

    function automatic logic [5:0] pair_code(logic [7:0] h, logic [7:0] b);
        if (h == ":" && b == ":") return K_PATH;
        if (h == "&" && b == "&") return K_ANDAND;
        if (h == "-" && b == ">") return K_ARROW;
        if (h == "=" && b == "=") return K_EQEQ;
        if (h == "=" && b == ">") return K_FATARROW;
        if (h == "!" && b == "=") return K_NOTEQ;
        if (h == "<" && b == "=") return K_LE;
        if (h == ">" && b == "=") return K_GE;
        return K_EOF;
    endfunction

    function automatic logic [5:0] alone_code(logic [7:0] h);
        case (h)
            "/": return K_SLASH;
            ":": return K_COLON;
            "-": return K_MINUS;
            "=": return K_ASSIGN;
            "<": return K_LT;
            ">": return K_GT;
            default: return K_UNREC;
        endcase
    endfunction

    task automatic start_token(logic [7:0] b);
        if (b == 8'd0)
        begin
            fresh.push_back('{K_EOF, cur_line, cur_col, 64'd0, 8'd0, 5'd0, 1'b1});
            clear_scanner();
            return;
        end
        if (is_blank(b))
        begin
            step_position(b);
            return;
        end
        tok_line = cur_line;
        tok_col = cur_col;
        kept_len = 0;
        keep_byte(b);
        step_position(b);
        if (is_letter(b) || b == "_")
            mode = SC_WORD;
        else if (is_num(b))
        begin
            mode = SC_NUM;
            negative = 1'b0;
            accum = 64'(b - "0");
        end
        else if (b == "/" || b == "-" || b == ":" || b == "&" || b == "=" ||
                 b == "!" || b == "<" || b == ">")
        begin
            held = b;
            mode = SC_HOLD;
        end
        else
            flush_token(single_code(b), 64'd0);
    endtask

    // Results caused by one accepted byte are left in fresh.
    task automatic scan_byte(logic [7:0] b);
        logic [5:0] pk;
        fresh.delete();
        case (mode)
            SC_WORD:
            begin
                if (is_word(b))
                begin
                    keep_byte(b);
                    step_position(b);
                    return;
                end
                flush_token(word_code(), 64'd0);
            end
            SC_NUM:
            begin
                if (is_num(b))
                begin
                    if (kept_len < KEEP_MAX)
                    begin
                        keep_byte(b);
                        add_digit(b);
                    end
                    step_position(b);
                    return;
                end
                flush_token(K_INT, number_value());
            end
            SC_NOTE:
            begin
                if (b != 8'd0 && b != "\n")
                begin
                    step_position(b);
                    return;
                end
                mode = SC_IDLE;
            end
            SC_HOLD:
            begin
                if (held == "/" && b == "/")
                begin
                    kept_len = 0;
                    mode = SC_NOTE;
                    step_position(b);
                    return;
                end
                if (held == "-" && is_num(b))
                begin
                    keep_byte(b);
                    step_position(b);
                    negative = 1'b1;
                    accum = 64'(b - "0");
                    mode = SC_NUM;
                    return;
                end
                pk = pair_code(held, b);
                if (pk != K_EOF)
                begin
                    keep_byte(b);
                    step_position(b);
                    flush_token(pk, 64'd0);
                    return;
                end
                flush_token(alone_code(held), 64'd0);
            end
            default: mode = SC_IDLE;
        endcase
        start_token(b);
    endtask

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in <= b;
        do @(posedge clk); while (in_stall);
        scan_byte(b);
        foreach (fresh[i]) expected_bytes.push_back(fresh[i]);
        @(negedge clk);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) source_bytes.push_back(s[i]);
    endtask

    task automatic make_random_token();
        int pick, n;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 20)
            push_text(keywords[$urandom_range(15)]);
        else if (pick < 35)
        begin
            n = ($urandom_range(19) == 0) ? $urandom_range(40, 31) : $urandom_range(8, 1);
            for (int i = 0; i < n; i++)
            begin
                do c = 8'($urandom_range(127)); while (!(is_word(c) && (i > 0 ||
                    !is_num(c))));
                source_bytes.push_back(c);
            end
        end
        else if (pick < 50)
        begin
            if ($urandom_range(1)) source_bytes.push_back("-");
            n = ($urandom_range(5) == 0) ? $urandom_range(34, 18) : $urandom_range(5, 1);
            for (int i = 0; i < n; i++) source_bytes.push_back(8'("0" + $urandom_range(9)));
        end
        else if (pick < 70)
            push_text(puncts[$urandom_range(32)]);
        else if (pick < 80)
            source_bytes.push_back(blanks[$urandom_range(5)]);
        else if (pick < 85)
        begin
            push_text("//");
            n = $urandom_range(6);
            for (int i = 0; i < n; i++) source_bytes.push_back(8'($urandom_range(126, 32)));
            if ($urandom_range(3) != 0) source_bytes.push_back("\n");
        end
        else if (pick < 97)
            source_bytes.push_back(8'($urandom_range(255)));
        else
            source_bytes.push_back(8'd0);
        if ($urandom_range(9) < 6) source_bytes.push_back(" ");
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        token_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected result transaction, kind %0d", token_kind);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (token_kind !== want.kind)
                begin
                    $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
                    errors++;
                end
                if (start_line !== want.line)
                begin
                    $error("start_line: expected %0d, got %0d", want.line, start_line);
                    errors++;
                end
                if (start_col !== want.col)
                begin
                    $error("start_col: expected %0d, got %0d", want.col, start_col);
                    errors++;
                end
                if (int_value !== want.value)
                begin
                    $error("int_value: expected %0d, got %0d", $signed(want.value),
                           int_value);
                    errors++;
                end
                if (text_char !== want.ch)
                begin
                    $error("text_char: expected %h, got %h", want.ch, text_char);
                    errors++;
                end
                if (text_index !== want.idx)
                begin
                    $error("text_index: expected %0d, got %0d", want.idx, text_index);
                    errors++;
                end
                if (last_of_token !== want.last)
                begin
                    $error("last_of_token: expected %0d, got %0d", want.last,
                           last_of_token);
                    errors++;
                end
            end
        end
    end

    // Typed rows carry the one result that the byte must cause; others use the scanner.
    stim_row_t directed [] = '{
        '{8'd0,  1'b1, '{K_EOF,   24'd1, 24'd1, 64'd0, 8'd0,  5'd0, 1'b1}},
        '{"#",   1'b1, '{K_UNREC, 24'd1, 24'd1, 64'd0, "#",   5'd0, 1'b1}},
        '{8'hFF, 1'b1, '{K_UNREC, 24'd1, 24'd2, 64'd0, 8'hFF, 5'd0, 1'b1}},
        '{"&",   1'b0, '{default: '0}},
        '{" ",   1'b1, '{K_UNREC, 24'd1, 24'd3, 64'd0, "&",   5'd0, 1'b1}},
        '{"!",   1'b0, '{default: '0}},
        '{"-",   1'b0, '{default: '0}},
        '{"7",   1'b0, '{default: '0}},
        '{"=",   1'b0, '{default: '0}},
        '{">",   1'b0, '{default: '0}},
        '{"/",   1'b0, '{default: '0}},
        '{"/",   1'b0, '{default: '0}},
        '{"x",   1'b0, '{default: '0}},
        '{"\n",  1'b0, '{default: '0}},
        '{"f",   1'b0, '{default: '0}},
        '{"n",   1'b0, '{default: '0}},
        '{":",   1'b0, '{default: '0}},
        '{":",   1'b0, '{default: '0}},
        '{"_",   1'b0, '{default: '0}},
        '{"9",   1'b0, '{default: '0}},
        '{"/",   1'b0, '{default: '0}},
        '{"/",   1'b0, '{default: '0}},
        '{8'd0,  1'b0, '{default: '0}}
    };

    initial
    begin
        int quarter, waited;
        clear_scanner();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[r])
        begin
            if (!directed[r].typed)
                send_byte(directed[r].ch);
            else
            begin
                while ($urandom_range(99) < sender_idle_pct)
                begin
                    in_valid <= 1'b0;
                    @(negedge clk);
                end
                in_valid <= 1'b1;
                char_in <= directed[r].ch;
                do @(posedge clk); while (in_stall);
                scan_byte(directed[r].ch);
                if (fresh.size() != 1 || fresh[0] != directed[r].res)
                begin
                    $error("scanner disagrees with table row %0d", r);
                    errors++;
                end
                expected_bytes.push_back(directed[r].res);
                @(negedge clk);
            end
        end

        while (source_bytes.size() < 270) make_random_token();
        source_bytes.push_back(8'd0);
        quarter = source_bytes.size() / 4;
        foreach (source_bytes[i])
        begin
            if (i == quarter)
            begin
                sender_idle_pct = 68;
                stall_pct = 0;
            end
            else if (i == 2 * quarter)
            begin
                sender_idle_pct = 0;
                stall_pct = 68;
            end
            else if (i == 3 * quarter)
            begin
                sender_idle_pct = 11;
                stall_pct = 11;
            end
            send_byte(source_bytes[i]);
        end
        in_valid <= 1'b0;

        waited = 0;
        while (expected_bytes.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (40) @(negedge clk);
        if (expected_bytes.size() != 0)
        begin
            $error("%0d expected result transactions never arrived", expected_bytes.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
